### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define PFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset
`define PFE_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/core/pfe_pkg.sv
// Types, constants and key square helpers of the Playfair stream encryptor
package pfe_pkg;

  localparam int SIDE   = 5;
  localparam int CELLS  = SIDE * SIDE;
  localparam int CELL_W = 5;
  localparam int SQ_W   = CELLS * CELL_W;
  localparam int CFG_W  = 50;
  localparam int POS_W  = 3;
  localparam int IDX_W  = 5;

  // Letter indices, A = 0
  localparam logic [CELL_W-1:0] LETTER_I = 5'd8;
  localparam logic [CELL_W-1:0] LETTER_J = 5'd9;
  localparam logic [CELL_W-1:0] LETTER_X = 5'd23;

  // ASCII codes
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [7:0] ASCII_CASE    = 8'd32;
  localparam logic [6:0] CHAR_BASE     = 7'd65;

  // Configuration register indices
  localparam logic [1:0] REG_ROWS_0_1 = 2'd0;
  localparam logic [1:0] REG_ROWS_2_3 = 2'd1;
  localparam logic [1:0] REG_ROW_4    = 2'd2;

  // Reset key square: M F H I K / U N O P Q / Z V W X Y / E L A R G / D S T B C
  localparam logic [49:0] RST_ROWS_0_1 = 50'd579938304662700;
  localparam logic [49:0] RST_ROWS_2_3 = 50'd229809901525689;
  localparam logic [24:0] RST_ROW_4    = 25'd2149955;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One digraph waiting to be enciphered
  typedef struct packed {
    logic [CELL_W-1:0] first;
    logic [CELL_W-1:0] second;
    logic              last;
    logic              done;
  } job_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  // First matching cell in row-major order; a missing letter sits at row 0, column 0
  function automatic pos_t locate(input logic [SQ_W-1:0] sq, input logic [CELL_W-1:0] letter);
    pos_t p;
    p = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[(r * SIDE + c) * CELL_W +: CELL_W] == letter) begin
          p.row = POS_W'(r);
          p.col = POS_W'(c);
        end
      end
    end
    return p;
  endfunction

  // Step one place along a row or column, wrapping at the edge
  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] v);
    return (v == POS_W'(SIDE - 1)) ? '0 : v + POS_W'(1);
  endfunction

  // Cell contents at a row and column
  function automatic logic [CELL_W-1:0] cell_at(input logic [SQ_W-1:0] sq, input pos_t p);
    logic [IDX_W-1:0]  idx;
    logic [CELL_W-1:0] v;
    idx = (IDX_W'(p.row) << 2) + IDX_W'(p.row) + IDX_W'(p.col);
    v   = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (idx == IDX_W'(i)) v = sq[i * CELL_W +: CELL_W];
    end
    return v;
  endfunction

endpackage

### rtl/core/pfe_if.sv
// Valid/ready stream interfaces for the input characters and cipher letters
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       message_end;

  modport source (output valid, output char_in, output message_end, input ready);
  modport sink   (input valid, input char_in, input message_end, output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_char;
  logic       run_last;
  logic       message_done;

  modport source (output valid, output cipher_char, output run_last, output message_done,
                  input ready);
  modport sink   (input valid, input cipher_char, input run_last, input message_done,
                  output ready);
endinterface

### rtl/core/pfe_front.sv
// Front end: folds and filters characters, pairs letters and queues digraphs
`include "assert_macros.svh"

module pfe_front (
  input  logic         clk,
  input  logic         rst,
  pfe_in_if.sink       in_ch,
  output logic         push,
  output pfe_pkg::job_t push_job,
  input  logic         full
);
  import pfe_pkg::*;

  logic [CELL_W-1:0] held;
  logic              pending;
  logic              phase;

  logic [7:0]        ch;
  logic              is_letter;
  logic [CELL_W-1:0] letter;
  logic              same;
  logic              has_j1;
  logic              has_j2;
  logic              two;
  logic              pend_after;
  logic [CELL_W-1:0] held_after;
  logic              need_push;
  logic              accept;

  // Case folding and letter classification
  always_comb begin
    ch = in_ch.char_in;
    if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) ch = ch - ASCII_CASE;
    is_letter = (ch >= ASCII_UPPER_A) && (ch <= ASCII_UPPER_Z);
    letter    = CELL_W'(ch - ASCII_UPPER_A);
    if (letter == LETTER_J) letter = LETTER_I;
  end

  // Digraphs caused by this item: a pair with the held letter, then end padding
  always_comb begin
    same       = (held == letter);
    has_j1     = is_letter && pending;
    pend_after = is_letter ? (!pending || same) : pending;
    held_after = is_letter ? letter : held;
    has_j2     = in_ch.message_end && pend_after;
    two        = has_j1 && has_j2;
    need_push  = has_j1 || has_j2;
  end

  always_comb begin
    if (has_j1 && !phase) begin
      push_job.first  = held;
      push_job.second = same ? LETTER_X : letter;
      push_job.last   = !has_j2;
      push_job.done   = in_ch.message_end && !has_j2;
    end else begin
      push_job.first  = held_after;
      push_job.second = LETTER_X;
      push_job.last   = 1'b1;
      push_job.done   = 1'b1;
    end
  end

  // An item that yields two digraphs is held until its first digraph has been pushed
  assign in_ch.ready = (!need_push || !full) && !(two && !phase);
  assign push        = in_ch.valid && need_push && !full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      pending <= 1'b0;
      phase   <= 1'b0;
    end else begin
      if (accept) begin
        held    <= held_after;
        pending <= pend_after && !in_ch.message_end;
        phase   <= 1'b0;
      end else if (in_ch.valid && two && !phase && !full) begin
        phase   <= 1'b1;
      end
    end
  end

  `PFE_ASSERT(a_two_needs_phase, clk, rst, (accept && two) |-> phase,
              "item with two digraphs accepted in one cycle")
  `PFE_NEVER(a_push_full, clk, rst, push && full, "push into a full queue")

endmodule

### rtl/core/pfe_queue.sv
// Short digraph queue between the front end and the cipher back end
`include "assert_macros.svh"

module pfe_queue #(
  parameter int DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfe_pkg::job_t push_job,
  output logic          full,
  output logic          pop_valid,
  output pfe_pkg::job_t pop_job,
  input  logic          pop
);
  import pfe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job   = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !push) count <= count - CNT_W'(1);
    end
  end

  `PFE_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count overrun")
  `PFE_ASSERT(a_ptr_gap, clk, rst,
              (count == '0 || count == CNT_W'(DEPTH)) |-> (wr_ptr == rd_ptr),
              "queue pointers disagree with count")

endmodule

### rtl/core/pfe_back.sv
// Back end: locates a digraph in the key square and sends the two cipher letters
`include "assert_macros.svh"

module pfe_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pfe_pkg::SQ_W-1:0]  sq,
  input  logic                      pop_valid,
  input  pfe_pkg::job_t             pop_job,
  output logic                      pop,
  pfe_out_if.source                 out_ch
);
  import pfe_pkg::*;

  // Locate stage
  logic              a_valid;
  pos_t              a_p1;
  pos_t              a_p2;
  logic              a_last;
  logic              a_done;

  // Output stage
  logic              b_valid;
  logic              b_second;
  logic [CELL_W-1:0] b_x;
  logic [CELL_W-1:0] b_y;
  logic              b_last;
  logic              b_done;

  logic              b_load;
  pos_t              px;
  pos_t              py;
  logic [CELL_W-1:0] sel;

  assign b_load = a_valid && (!b_valid || (b_second && out_ch.ready));
  assign pop    = pop_valid && (!a_valid || b_load);

  always_ff @(posedge clk) begin
    if (pop) begin
      a_p1   <= locate(sq, pop_job.first);
      a_p2   <= locate(sq, pop_job.second);
      a_last <= pop_job.last;
      a_done <= pop_job.done;
    end
  end

  // Playfair rule: row shifts right, column shifts down, else rectangle corners
  always_comb begin
    if (a_p1.row == a_p2.row) begin
      px = '{row: a_p1.row, col: wrap_inc(a_p1.col)};
      py = '{row: a_p2.row, col: wrap_inc(a_p2.col)};
    end else if (a_p1.col == a_p2.col) begin
      px = '{row: wrap_inc(a_p1.row), col: a_p1.col};
      py = '{row: wrap_inc(a_p2.row), col: a_p2.col};
    end else begin
      px = '{row: a_p1.row, col: a_p2.col};
      py = '{row: a_p2.row, col: a_p1.col};
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_x    <= cell_at(sq, px);
      b_y    <= cell_at(sq, py);
      b_last <= a_last;
      b_done <= a_done;
    end
  end

  // Stage valids and letter select
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      b_second <= 1'b0;
    end else begin
      if (pop) a_valid <= 1'b1;
      else if (b_load) a_valid <= 1'b0;
      if (b_load) begin
        b_valid  <= 1'b1;
        b_second <= 1'b0;
      end else if (b_valid && out_ch.ready) begin
        if (b_second) b_valid <= 1'b0;
        else b_second <= 1'b1;
      end
    end
  end

  assign sel                 = b_second ? b_y : b_x;
  assign out_ch.valid        = b_valid;
  assign out_ch.cipher_char  = CHAR_BASE + 7'(sel);
  assign out_ch.run_last     = b_second && b_last;
  assign out_ch.message_done = b_second && b_done;

  `PFE_ASSERT(a_second_follows, clk, rst,
              (b_valid && !b_second && out_ch.ready) |=> (b_valid && b_second),
              "second cipher letter lost after first transfer")
  `PFE_NEVER(a_lone_first, clk, rst, b_load && b_valid && !b_second,
             "digraph overwritten before its letters were sent")

endmodule

### rtl/core/playfair_stream_encryptor.sv
// Top level of the Playfair stream encryptor: key square registers, front, queue, back
//
// in_ch carries one raw ASCII character per transfer, with message_end on the
// last character of a message. Lower case folds to upper, other bytes are
// dropped, J counts as I. out_ch carries cipher letters as upper-case ASCII;
// run_last marks the last letter caused by an input transfer and message_done
// the last letter of a message. The user must write the key square through cfg_write,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// Flow: a digraph is written into the queue, popped into the locate stage and
// loaded into the output stage, which offers its first cipher letter. An input
// character is taken every cycle while the queue can take its digraphs; one that
// yields two digraphs is held until the first of them is queued. Each digraph
// leaves as two letters, first then second, on the output port, which sets the
// sustained digraph rate.
// Reset clears the held letter, the digraph queue and both back-end stages and
// restores the default key square. When the receiver stalls, the output letter
// holds, the back end and queue fill, and in_ch.ready drops for characters that
// would queue a digraph once the queue of QUEUE_DEPTH digraphs is full.
module playfair_stream_encryptor #(
  parameter int QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  pfe_in_if.sink                    in_ch,
  pfe_out_if.source                 out_ch,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [pfe_pkg::CFG_W-1:0] cfg_data
);
  import pfe_pkg::*;

  logic [49:0]     square_rows_0_1;
  logic [49:0]     square_rows_2_3;
  logic [24:0]     square_row_4;
  logic [SQ_W-1:0] sq;

  logic            push;
  job_t            push_job;
  logic            full;
  logic            pop_valid;
  job_t            pop_job;
  logic            pop;

  // Key square configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      square_rows_0_1 <= RST_ROWS_0_1;
      square_rows_2_3 <= RST_ROWS_2_3;
      square_row_4    <= RST_ROW_4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS_0_1: square_rows_0_1 <= cfg_data;
        REG_ROWS_2_3: square_rows_2_3 <= cfg_data;
        REG_ROW_4:    square_row_4    <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  assign sq = {square_row_4, square_rows_2_3, square_rows_0_1};

  pfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  pfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sq        (sq),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
